// ----- hdl/tfet_pkg.sv -----
// Shared types and constants for the touch frame event tracker.
// Used by tfet_ctrl, tfet_dp and touch_frame_event_tracker_top; no dependencies.
package tfet_pkg;

  localparam int MAX_POINTS = 5;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [MAX_POINTS-1:0] pmask_t;

  localparam logic CMD_STATUS = 1'b0;
  localparam logic CMD_POINT  = 1'b1;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_MOVED    = 2'd1,
    EV_RELEASED = 2'd2,
    EV_ERROR    = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ERR,
    S_MASK,
    S_PT,
    S_REL
  } state_t;

  typedef struct packed {
    logic capture;
    logic abandon;
    logic open_frame;
    logic start_close;
    logic take_point;
    logic emit_error;
    logic build_mask;
    logic emit_point;
    logic emit_release;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_point;
    logic st_ready;
    logic cnt_big;
    logic cnt_zero;
    logic point_ok;
    logic has_ev;
    logic closing;
    logic mask_empty;
    logic slot_free;
  } ctl_sts_t;

endpackage

// ----- hdl/tfet_ctrl.sv -----
// Sequencer for the touch frame event tracker.
// Depends on tfet_pkg; drives tfet_dp through ctl_cmd_t and reads ctl_sts_t.
module tfet_ctrl import tfet_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.is_point) begin
          state_next = sts.point_ok ? S_MASK : S_IDLE;
        end else if (!sts.st_ready) begin
          state_next = S_IDLE;
        end else if (sts.cnt_big) begin
          state_next = S_ERR;
        end else if (sts.cnt_zero) begin
          state_next = S_MASK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.slot_free) state_next = S_IDLE;
      end
      S_MASK: begin
        state_next = S_PT;
      end
      S_PT: begin
        if (!sts.has_ev || sts.slot_free) state_next = sts.closing ? S_REL : S_IDLE;
      end
      S_REL: begin
        if (sts.mask_empty) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        cmd.abandon     = !sts.is_point && sts.st_ready;
        cmd.open_frame  = !sts.is_point && sts.st_ready && !sts.cnt_big && !sts.cnt_zero;
        cmd.start_close = !sts.is_point && sts.st_ready && !sts.cnt_big && sts.cnt_zero;
        cmd.take_point  = sts.is_point && sts.point_ok;
      end
      S_ERR: begin
        cmd.emit_error = sts.slot_free;
      end
      S_MASK: begin
        cmd.build_mask = 1'b1;
      end
      S_PT: begin
        cmd.emit_point = sts.has_ev && sts.slot_free;
      end
      S_REL: begin
        cmd.commit       = sts.mask_empty;
        cmd.emit_release = !sts.mask_empty && sts.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/tfet_dp.sv -----
// Datapath of the touch frame event tracker: frame stores, match logic,
// release mask and output register. Depends on tfet_pkg; commanded by tfet_ctrl.
module tfet_dp import tfet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output ctl_sts_t    sts,
  input  logic        in_cmd,
  input  logic [7:0]  in_status,
  input  logic [7:0]  in_id,
  input  logic [15:0] in_x,
  input  logic [15:0] in_y,
  input  logic [15:0] in_size,
  output logic        out_valid,
  input  logic        out_ready,
  output ev_kind_t    out_kind,
  output logic [7:0]  out_id,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [15:0] out_size,
  output logic        out_last
);

  // Captured item
  logic        c_cmd;
  logic [7:0]  c_status;
  logic [7:0]  c_id;
  logic [15:0] c_x, c_y, c_size;

  // Frame stores
  logic [7:0]  prev_id   [MAX_POINTS];
  logic [15:0] prev_x    [MAX_POINTS];
  logic [15:0] prev_y    [MAX_POINTS];
  logic [15:0] prev_size [MAX_POINTS];
  logic [7:0]  cur_id    [MAX_POINTS];
  logic [15:0] cur_x     [MAX_POINTS];
  logic [15:0] cur_y     [MAX_POINTS];
  logic [15:0] cur_size  [MAX_POINTS];
  cnt_t        prev_count, cur_count, expected_count;
  logic        frame_open;

  // Pending work
  logic        has_ev, closing;
  ev_kind_t    pt_kind;
  pmask_t      rel_mask;

  logic        found, moved;
  idx_t        match_idx, rel_idx;
  pmask_t      rel_rest, mask_new;
  logic [3:0]  cnt4;
  logic        slot_free;

  assign cnt4      = c_status[3:0];
  assign slot_free = !out_valid || out_ready;

  // First match by id among the previous points
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < prev_count && prev_id[i] == c_id) begin
        found     = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
    moved = (prev_x[match_idx] != c_x) || (prev_y[match_idx] != c_y);
  end

  // Previous points absent from the current frame
  always_comb begin
    logic hit;
    for (int i = 0; i < MAX_POINTS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < MAX_POINTS; j++) begin
        if (CNT_W'(j) < cur_count && cur_id[j] == prev_id[i]) hit = 1'b1;
      end
      mask_new[i] = closing && (CNT_W'(i) < prev_count) && !hit;
    end
  end

  // Lowest pending release
  always_comb begin
    rel_idx = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (rel_mask[i]) rel_idx = IDX_W'(i);
    end
    rel_rest = rel_mask & ~(pmask_t'(1) << rel_idx);
  end

  always_comb begin
    sts.is_point   = (c_cmd == CMD_POINT);
    sts.st_ready   = c_status[7];
    sts.cnt_big    = cnt4 > 4'(MAX_POINTS);
    sts.cnt_zero   = (cnt4 == 4'd0);
    sts.point_ok   = frame_open && (cur_count < CNT_W'(MAX_POINTS));
    sts.has_ev     = has_ev;
    sts.closing    = closing;
    sts.mask_empty = (rel_mask == '0);
    sts.slot_free  = slot_free;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count     <= '0;
      cur_count      <= '0;
      expected_count <= '0;
      frame_open     <= 1'b0;
      has_ev         <= 1'b0;
      closing        <= 1'b0;
      rel_mask       <= '0;
      out_valid      <= 1'b0;
    end else begin
      // drop the partial frame; open the next one when the status asks for it
      if (cmd.abandon) begin
        frame_open <= cmd.open_frame;
        cur_count  <= '0;
      end
      if (cmd.open_frame) begin
        expected_count <= cnt4[CNT_W-1:0];
      end
      if (cmd.start_close) begin
        has_ev  <= 1'b0;
        closing <= 1'b1;
      end
      if (cmd.take_point) begin
        has_ev    <= !found || moved;
        cur_count <= cnt_t'(cur_count + 1'b1);
        closing   <= cnt_t'(cur_count + 1'b1) >= expected_count;
      end
      if (cmd.build_mask) begin
        rel_mask <= mask_new;
      end
      if (cmd.emit_release) begin
        rel_mask <= rel_rest;
      end
      if (cmd.commit) begin
        prev_count <= cur_count;
        frame_open <= 1'b0;
      end
      if (cmd.emit_error || cmd.emit_point || cmd.emit_release) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_cmd    <= in_cmd;
      c_status <= in_status;
      c_id     <= in_id;
      c_x      <= in_x;
      c_y      <= in_y;
      c_size   <= in_size;
    end
    if (cmd.take_point) begin
      pt_kind                                <= found ? EV_MOVED : EV_PRESSED;
      cur_id[cur_count[IDX_W-1:0]]   <= c_id;
      cur_x[cur_count[IDX_W-1:0]]    <= c_x;
      cur_y[cur_count[IDX_W-1:0]]    <= c_y;
      cur_size[cur_count[IDX_W-1:0]] <= c_size;
    end
    if (cmd.commit) begin
      prev_id   <= cur_id;
      prev_x    <= cur_x;
      prev_y    <= cur_y;
      prev_size <= cur_size;
    end
    if (cmd.emit_error) begin
      out_kind <= EV_ERROR;
      out_id   <= '0;
      out_x    <= '0;
      out_y    <= '0;
      out_size <= '0;
      out_last <= 1'b1;
    end else if (cmd.emit_point) begin
      out_kind <= pt_kind;
      out_id   <= c_id;
      out_x    <= c_x;
      out_y    <= c_y;
      out_size <= c_size;
      out_last <= (rel_mask == '0);
    end else if (cmd.emit_release) begin
      out_kind <= EV_RELEASED;
      out_id   <= prev_id[rel_idx];
      out_x    <= prev_x[rel_idx];
      out_y    <= prev_y[rel_idx];
      out_size <= prev_size[rel_idx];
      out_last <= (rel_rest == '0);
    end
  end

endmodule

// ----- hdl/touch_frame_event_tracker_top.sv -----
// Multitouch press / move / release tracker: top level.
// A status item announces a frame of point items; each point is matched by id
// against the previous frame and gives Pressed (new id) or Moved (x or y
// changed). When the frame is complete, or at once for a ready status with a
// count of zero, every previous point whose id is missing gives Released, in
// previous-frame order, and the new frame replaces the previous one. A ready
// status with a count above MAX_POINTS (5) gives one frame-error result and
// keeps the previous frame; any ready status drops a partial frame. A status
// with bit 7 clear and a point outside an open frame give no result.
// Items are handled one at a time: a status that only opens or drops a frame,
// or an ignored item, passes accept and decode; an error adds an error step.
// A point passes accept, decode, mask and point steps, then the release walk
// when it closes the frame; a ready status with a count of zero takes the same
// path. The release walk advances one mask entry per cycle while the output
// register is free; a full register not taken stalls any emitting step. m_tlast
// marks the last result of an item; an item may give no result at all.
// Depends on tfet_pkg, tfet_ctrl and tfet_dp.
module touch_frame_event_tracker_top import tfet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // status_byte[7:0], point_id[15:8], point_x[31:16],
                                // point_y[47:32], point_size[63:48]
  input  logic        s_tuser,  // command: 0 status item, 1 point record
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // event_id[7:0], event_x[23:8], event_y[39:24],
                                // event_size[55:40]
  output logic [1:0]  m_tuser,  // event_kind
  output logic        m_tlast   // last_of_run
);

  ctl_cmd_t    cmd;
  ctl_sts_t    sts;
  ev_kind_t    ev_kind;
  logic [7:0]  ev_id;
  logic [15:0] ev_x, ev_y, ev_size;

  // Sequencer: accepts an item only when the previous one is fully handled
  tfet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Frame stores, matching and the output register
  tfet_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_cmd    (s_tuser),
    .in_status (s_tdata[7:0]),
    .in_id     (s_tdata[15:8]),
    .in_x      (s_tdata[31:16]),
    .in_y      (s_tdata[47:32]),
    .in_size   (s_tdata[63:48]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (ev_kind),
    .out_id    (ev_id),
    .out_x     (ev_x),
    .out_y     (ev_y),
    .out_size  (ev_size),
    .out_last  (m_tlast)
  );

  // Pack the result fields, lowest field first
  assign m_tdata = {ev_size, ev_y, ev_x, ev_id};
  assign m_tuser = ev_kind;

endmodule
